@@ rtl/lcp_pkg.sv @@
package lcp_pkg;

  localparam logic [7:0] CHAR_LF    = 8'd10;
  localparam logic [7:0] CHAR_CR    = 8'd13;
  localparam logic [7:0] CHAR_TAB   = 8'd9;
  localparam logic [7:0] CHAR_SPACE = " ";
  localparam logic [7:0] CHAR_COMMA = ",";
  localparam logic [7:0] CHAR_COLON = ":";
  localparam logic [7:0] CHAR_PLUS  = "+";
  localparam logic [7:0] CHAR_MINUS = "-";
  localparam logic [7:0] CHAR_ZERO  = "0";
  localparam logic [7:0] CHAR_NINE  = "9";
  localparam logic [7:0] FIELD_COLOUR = "C";
  localparam logic [7:0] FIELD_ERROR  = "E";

  // colour tokens, upper case, left aligned in 6 characters
  localparam logic [47:0] WORD_BLUE   = {"BLUE", 16'h0000};
  localparam logic [47:0] WORD_PURPLE = "PURPLE";
  localparam logic [47:0] WORD_BROWN  = {"BROWN", 8'h00};

  localparam logic [2:0] LEN_BLUE   = 3'd4;
  localparam logic [2:0] LEN_PURPLE = 3'd6;
  localparam logic [2:0] LEN_BROWN  = 3'd5;

  // event codes of the error field (16-bit two's complement)
  localparam logic [15:0] EV_RIGHT    = 16'd1000;
  localparam logic [15:0] EV_LEFT     = 16'hFC18;  // -1000
  localparam logic [15:0] EV_PLATFORM = 16'd2000;
  localparam logic [15:0] EV_PURPLE   = 16'd3000;
  localparam logic [15:0] EV_BROWN    = 16'd4000;
  localparam logic [15:0] EV_STOP     = 16'd9999;

  typedef enum logic [2:0] {
    CMD_RIGHT    = 3'd0,
    CMD_LEFT     = 3'd1,
    CMD_PLATFORM = 3'd2,
    CMD_PURPLE   = 3'd3,
    CMD_BROWN    = 3'd4,
    CMD_STOP     = 3'd5
  } cmd_t;

  typedef struct packed {
    logic        is_command;
    logic [2:0]  command_code;
    logic [15:0] track_error;
  } scan_res_t;

  function automatic logic [7:0] up_case(input logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] word_char(input logic [47:0] w, input logic [2:0] k);
    logic [7:0] c;
    case (k)
      3'd0:    c = w[47:40];
      3'd1:    c = w[39:32];
      3'd2:    c = w[31:24];
      3'd3:    c = w[23:16];
      3'd4:    c = w[15:8];
      3'd5:    c = w[7:0];
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHAR_SPACE) || (c == CHAR_TAB);
  endfunction

endpackage

@@ rtl/lcp_ram.sv @@
module lcp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 48,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/lcp_scan.sv @@
module lcp_scan
  import lcp_pkg::*;
#(
  parameter int LINE_DEPTH = 48,
  parameter int AW         = $clog2(LINE_DEPTH)
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  logic [AW-1:0]   start_len,
  output logic [AW-1:0]   rd_addr,
  input  logic [7:0]      rd_data,
  output logic            idle,
  output logic            res_valid,
  input  logic            res_ready,
  output scan_res_t       res
);

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_FIND   = 8'b0000_0010,
    S_CBLANK = 8'b0000_0100,
    S_CTOK   = 8'b0000_1000,
    S_EBLANK = 8'b0001_0000,
    S_EDIG   = 8'b0010_0000,
    S_MAP    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } scan_state_t;

  scan_state_t state, state_next;
  logic [AW-1:0] idx, idx_next;
  logic [AW-1:0] len, len_next;
  logic [7:0]    prev, prev_next;
  logic          c_found, c_found_next;
  logic          e_found, e_found_next;
  logic [AW-1:0] c_pos, c_pos_next;
  logic [AW-1:0] e_pos, e_pos_next;
  logic [2:0]    tok_len, tok_len_next;
  logic          m_blue, m_blue_next;
  logic          m_purple, m_purple_next;
  logic          m_brown, m_brown_next;
  logic          neg, neg_next;
  logic          digits, digits_next;
  logic [15:0]   val, val_next;
  scan_res_t     res_next;

  logic          at_end;
  logic [AW-1:0] e_start;
  logic [7:0]    uc;
  logic          delim;
  logic          is_digit;

  // rd_data always holds the byte at idx (the RAM read was issued at idx_next in the cycle before)
  assign at_end   = (idx >= len);
  assign e_start  = e_found ? e_pos : '0;
  assign uc       = up_case(rd_data);
  assign delim    = (rd_data == CHAR_COMMA) || is_blank(rd_data);
  assign is_digit = (rd_data >= CHAR_ZERO) && (rd_data <= CHAR_NINE);

  assign rd_addr   = idx_next;
  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_DONE);

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    len_next      = len;
    prev_next     = prev;
    c_found_next  = c_found;
    e_found_next  = e_found;
    c_pos_next    = c_pos;
    e_pos_next    = e_pos;
    tok_len_next  = tok_len;
    m_blue_next   = m_blue;
    m_purple_next = m_purple;
    m_brown_next  = m_brown;
    neg_next      = neg;
    digits_next   = digits;
    val_next      = val;
    res_next      = res;
    unique case (state)
      S_IDLE: begin
        idx_next = '0;
        if (start) begin
          len_next     = start_len;
          c_found_next = 1'b0;
          e_found_next = 1'b0;
          neg_next     = 1'b0;
          digits_next  = 1'b0;
          val_next     = '0;
          state_next   = S_FIND;
        end
      end
      S_FIND: begin
        // one pass finds the first C: and the first E:
        if (at_end) begin
          if (c_found) begin
            idx_next   = c_pos;
            state_next = S_CBLANK;
          end else begin
            idx_next   = e_start;
            state_next = S_EBLANK;
          end
        end else begin
          if (idx != '0 && rd_data == CHAR_COLON) begin
            if (!c_found && up_case(prev) == FIELD_COLOUR) begin
              c_found_next = 1'b1;
              c_pos_next   = idx + AW'(1);
            end
            if (!e_found && up_case(prev) == FIELD_ERROR) begin
              e_found_next = 1'b1;
              e_pos_next   = idx + AW'(1);
            end
          end
          prev_next = rd_data;
          idx_next  = idx + AW'(1);
        end
      end
      S_CBLANK: begin
        if (at_end) begin
          idx_next   = e_start;
          state_next = S_EBLANK;
        end else if (is_blank(rd_data)) begin
          idx_next = idx + AW'(1);
        end else begin
          // token starts here; re-read this byte in S_CTOK
          tok_len_next  = '0;
          m_blue_next   = 1'b1;
          m_purple_next = 1'b1;
          m_brown_next  = 1'b1;
          state_next    = S_CTOK;
        end
      end
      S_CTOK: begin
        if (at_end || delim) begin
          res_next.is_command  = 1'b1;
          res_next.track_error = '0;
          if (tok_len == LEN_BLUE && m_blue) begin
            res_next.command_code = CMD_PLATFORM;
            state_next            = S_DONE;
          end else if (tok_len == LEN_PURPLE && m_purple) begin
            res_next.command_code = CMD_PURPLE;
            state_next            = S_DONE;
          end else if (tok_len == LEN_BROWN && m_brown) begin
            res_next.command_code = CMD_BROWN;
            state_next            = S_DONE;
          end else begin
            idx_next   = e_start;
            state_next = S_EBLANK;
          end
        end else begin
          m_blue_next   = m_blue && (uc == word_char(WORD_BLUE, tok_len));
          m_purple_next = m_purple && (uc == word_char(WORD_PURPLE, tok_len));
          m_brown_next  = m_brown && (uc == word_char(WORD_BROWN, tok_len));
          // saturate: any token this long fails the length check
          if (tok_len != 3'd7) begin
            tok_len_next = tok_len + 3'd1;
          end
          idx_next = idx + AW'(1);
        end
      end
      S_EBLANK: begin
        if (at_end) begin
          state_next = S_IDLE;
        end else if (is_blank(rd_data)) begin
          idx_next = idx + AW'(1);
        end else if (rd_data == CHAR_MINUS) begin
          neg_next   = 1'b1;
          idx_next   = idx + AW'(1);
          state_next = S_EDIG;
        end else if (rd_data == CHAR_PLUS) begin
          idx_next   = idx + AW'(1);
          state_next = S_EDIG;
        end else begin
          state_next = S_EDIG;
        end
      end
      S_EDIG: begin
        if (at_end || !is_digit) begin
          if (digits) begin
            val_next   = neg ? (16'd0 - val) : val;
            state_next = S_MAP;
          end else begin
            state_next = S_IDLE;
          end
        end else begin
          // value wraps modulo 2^16
          val_next    = (val << 3) + (val << 1) + {12'd0, rd_data[3:0]};
          digits_next = 1'b1;
          idx_next    = idx + AW'(1);
        end
      end
      S_MAP: begin
        res_next.is_command   = 1'b1;
        res_next.command_code = CMD_RIGHT;
        res_next.track_error  = '0;
        if (val == EV_RIGHT) begin
          res_next.command_code = CMD_RIGHT;
        end else if (val == EV_LEFT) begin
          res_next.command_code = CMD_LEFT;
        end else if (val == EV_PLATFORM) begin
          res_next.command_code = CMD_PLATFORM;
        end else if (val == EV_PURPLE) begin
          res_next.command_code = CMD_PURPLE;
        end else if (val == EV_BROWN) begin
          res_next.command_code = CMD_BROWN;
        end else if (val == EV_STOP) begin
          res_next.command_code = CMD_STOP;
        end else begin
          res_next.is_command  = 1'b0;
          res_next.track_error = val;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      state <= state_next;
      idx   <= idx_next;
    end
    len      <= len_next;
    prev     <= prev_next;
    c_found  <= c_found_next;
    e_found  <= e_found_next;
    c_pos    <= c_pos_next;
    e_pos    <= e_pos_next;
    tok_len  <= tok_len_next;
    m_blue   <= m_blue_next;
    m_purple <= m_purple_next;
    m_brown  <= m_brown_next;
    neg      <= neg_next;
    digits   <= digits_next;
    val      <= val_next;
    res      <= res_next;
  end

endmodule

@@ rtl/text_line_command_parser_core.sv @@
// Line command parser. Characters are stored in a line RAM of LINE_DEPTH
// entries (at most LINE_DEPTH-1 characters per line; a further character
// drops the line). CR or LF on a non-empty line starts the scanner, which
// walks the line RAM through its single read port, one byte per cycle: one
// pass finds the C: and E: fields, then the colour token and, if no colour
// matched, the signed number are read. in_ready stays low while a line is
// scanned and while the finished result waits for the output register to
// free up. A finished result sits in the output register, and characters of
// the next line are taken while it waits.
module text_line_command_parser_core
  import lcp_pkg::*;
#(
  parameter int LINE_DEPTH = 48
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         data_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_command,
  output logic [2:0]         command_code,
  output logic signed [15:0] track_error
);

  localparam int AW = $clog2(LINE_DEPTH);

  logic [AW-1:0] line_length;
  logic          in_take;
  logic          is_term;
  logic          ram_we;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic          scan_idle;
  logic          scan_start;
  logic          res_valid;
  logic          res_ready;
  scan_res_t     res;

  assign in_ready   = scan_idle;
  assign in_take    = in_valid && in_ready;
  assign is_term    = (data_byte == CHAR_LF) || (data_byte == CHAR_CR);
  assign scan_start = in_take && is_term && (line_length != '0);
  assign ram_we     = in_take && !is_term && (line_length != AW'(LINE_DEPTH - 1));
  assign res_ready  = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_length <= '0;
    end else if (in_take) begin
      if (is_term || line_length == AW'(LINE_DEPTH - 1)) begin
        line_length <= '0;
      end else begin
        line_length <= line_length + AW'(1);
      end
    end
  end

  lcp_ram #(
    .WIDTH (8),
    .DEPTH (LINE_DEPTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (line_length),
    .wdata (data_byte),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  lcp_scan #(
    .LINE_DEPTH (LINE_DEPTH)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .start     (scan_start),
    .start_len (line_length),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .idle      (scan_idle),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      is_command   <= res.is_command;
      command_code <= res.command_code;
      track_error  <= res.track_error;
    end
  end

endmodule

@@ rtl/lcp_checker.sv @@
module lcp_checker
  import lcp_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               is_command,
  input logic [2:0]         command_code,
  input logic signed [15:0] track_error
);

  // a held result keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(is_command) &&
      $stable(command_code) && $stable(track_error))
    else $error("result changed while stalled");

  a_cmd_zero_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_command |-> track_error == 16'sd0)
    else $error("command result with nonzero error");

  a_err_zero_cmd: assert property (@(posedge clk) disable iff (rst)
    out_valid && !is_command |-> command_code == CMD_RIGHT)
    else $error("tracking result with nonzero command code");

  a_code_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_command |-> command_code <= CMD_STOP)
    else $error("command code out of range");

  // a new result only appears after a scan, which holds input off
  a_new_after_scan: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result without a preceding scan");

endmodule

bind text_line_command_parser_core lcp_checker u_lcp_checker (.*);

@@ test/text_line_command_parser_core_tb.sv @@
module text_line_command_parser_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcp_pkg::*;

  localparam int LINE_DEPTH  = 48;
  // covers the worst scan of a full line, with margin
  localparam int SCAN_SETTLE = 3 * LINE_DEPTH + 40;
  localparam int CYCLE_LIMIT = 2_000_000;
  localparam int RANDOM_BYTES = 850;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [7:0] data_byte = 8'h00;
  logic out_valid;
  logic out_ready = 1'b0;
  logic is_command;
  logic [2:0] command_code;
  logic signed [15:0] track_error;

  text_line_command_parser_core #(
    .LINE_DEPTH(LINE_DEPTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .data_byte(data_byte),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .is_command(is_command),
    .command_code(command_code),
    .track_error(track_error)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // line buffer as the parser sees it
  logic [7:0] line_mem [LINE_DEPTH];
  int line_len = 0;
  scan_res_t pending_scans[$];

  logic [7:0] draft[$];
  int fail_count = 0;
  int bytes_sent = 0;
  int cycle_count = 0;
  bit calm = 1'b0;
  int hold_left = 0;
  int pick;
  scan_res_t want;

  function automatic logic [7:0] to_upper(logic [7:0] c);
    if (c >= "a" && c <= "z") begin
      return c - 8'd32;
    end
    return c;
  endfunction

  function automatic int find_field(logic [7:0] letter);
    int i;
    for (i = 0; i + 1 < line_len; i++) begin
      if (to_upper(line_mem[i]) == letter && line_mem[i + 1] == CHAR_COLON) begin
        return i + 2;
      end
    end
    return -1;
  endfunction

  function automatic int skip_blanks(int i);
    while (i < line_len && (line_mem[i] == CHAR_SPACE || line_mem[i] == CHAR_TAB)) begin
      i++;
    end
    return i;
  endfunction

  function automatic bit token_equals(int start, string word);
    int stop;
    int j;
    stop = start;
    while (stop < line_len && line_mem[stop] != CHAR_COMMA &&
           line_mem[stop] != CHAR_SPACE && line_mem[stop] != CHAR_TAB) begin
      stop++;
    end
    if (stop - start != word.len()) begin
      return 1'b0;
    end
    for (j = 0; j < word.len(); j++) begin
      if (to_upper(line_mem[start + j]) != word[j]) begin
        return 1'b0;
      end
    end
    return 1'b1;
  endfunction

  function automatic int colour_command();
    int i;
    i = find_field(FIELD_COLOUR);
    if (i < 0) begin
      return -1;
    end
    i = skip_blanks(i);
    if (i >= line_len) begin
      return -1;
    end
    if (token_equals(i, "BLUE")) begin
      return int'(CMD_PLATFORM);
    end
    if (token_equals(i, "PURPLE")) begin
      return int'(CMD_PURPLE);
    end
    if (token_equals(i, "BROWN")) begin
      return int'(CMD_BROWN);
    end
    return -1;
  endfunction

  function automatic bit parse_number(output logic [15:0] val);
    int i;
    logic [15:0] v;
    bit neg;
    bit seen;
    v = 16'd0;
    neg = 1'b0;
    seen = 1'b0;
    val = 16'd0;
    i = find_field(FIELD_ERROR);
    if (i < 0) begin
      i = 0;
    end
    i = skip_blanks(i);
    if (i >= line_len) begin
      return 1'b0;
    end
    if (line_mem[i] == CHAR_MINUS) begin
      neg = 1'b1;
      i++;
    end else if (line_mem[i] == CHAR_PLUS) begin
      i++;
    end
    while (i < line_len && line_mem[i] >= CHAR_ZERO && line_mem[i] <= CHAR_NINE) begin
      seen = 1'b1;
      v = v * 16'd10 + {8'h00, line_mem[i] - CHAR_ZERO};
      i++;
    end
    if (!seen) begin
      return 1'b0;
    end
    if (neg) begin
      v = 16'd0 - v;
    end
    val = v;
    return 1'b1;
  endfunction

  function automatic void scan_line();
    int cmd;
    logic [15:0] e;
    scan_res_t r;
    r = '0;
    cmd = colour_command();
    if (cmd >= 0) begin
      r.is_command = 1'b1;
      r.command_code = 3'(cmd);
      pending_scans.push_back(r);
    end else if (parse_number(e)) begin
      case (e)
        EV_RIGHT:    cmd = int'(CMD_RIGHT);
        EV_LEFT:     cmd = int'(CMD_LEFT);
        EV_PLATFORM: cmd = int'(CMD_PLATFORM);
        EV_PURPLE:   cmd = int'(CMD_PURPLE);
        EV_BROWN:    cmd = int'(CMD_BROWN);
        EV_STOP:     cmd = int'(CMD_STOP);
        default:     cmd = -1;
      endcase
      if (cmd >= 0) begin
        r.is_command = 1'b1;
        r.command_code = 3'(cmd);
      end else begin
        r.track_error = e;
      end
      pending_scans.push_back(r);
    end
    line_len = 0;
  endfunction

  function automatic void parse_char(logic [7:0] b);
    if (b == CHAR_LF || b == CHAR_CR) begin
      if (line_len != 0) begin
        scan_line();
      end
    end else if (line_len < LINE_DEPTH - 1) begin
      line_mem[line_len] = b;
      line_len++;
    end else begin
      line_len = 0;
    end
  endfunction

  function automatic int pick_gap();
    int r;
    if (calm) begin
      return 0;
    end
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end
    if (r < 88) begin
      return $urandom_range(3, 1);
    end
    if (r < 97) begin
      return $urandom_range(20, 4);
    end
    return $urandom_range(120, 40);
  endfunction

  // called at a rising edge; returns at a rising edge
  task automatic send_byte(logic [7:0] b);
    int gap;
    in_valid <= 1'b1;
    data_byte <= b;
    do @(posedge clk); while (!in_ready);
    parse_char(b);
    bytes_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  function automatic void add_text(string s);
    int i;
    for (i = 0; i < s.len(); i++) begin
      draft.push_back(s[i]);
    end
  endfunction

  task automatic send_draft();
    while (draft.size() != 0) begin
      send_byte(draft.pop_front());
    end
  endtask

  task automatic send_line(string s, logic [7:0] term);
    add_text(s);
    draft.push_back(term);
    send_draft();
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_scans.size() != 0) begin
      @(posedge clk);
    end
    repeat (SCAN_SETTLE) @(posedge clk);
  endtask

  function automatic string mixed_case(string s);
    string t;
    int i;
    t = s;
    for (i = 0; i < t.len(); i++) begin
      if (((t[i] >= "a" && t[i] <= "z") || (t[i] >= "A" && t[i] <= "Z")) &&
          $urandom_range(1)) begin
        t.putc(i, t[i] ^ 8'h20);
      end
    end
    return t;
  endfunction

  function automatic string blanks();
    case ($urandom_range(5))
      0: return " ";
      1: return "\t";
      2: return " \t ";
      default: return "";
    endcase
  endfunction

  function automatic string sign_text();
    case ($urandom_range(3))
      0: return "-";
      1: return "+";
      default: return "";
    endcase
  endfunction

  function automatic string number_text();
    case ($urandom_range(9))
      0, 1, 2, 3: begin
        case ($urandom_range(7))
          0: return "1000";
          1: return "-1000";
          2: return "2000";
          3: return "+3000";
          4: return "4000";
          5: return "9999";
          6: return "01000";
          default: return "-64536";  // wraps onto the right-turn code
        endcase
      end
      4, 5, 6: return $sformatf("%s%0d", sign_text(), $urandom_range(999));
      7: return $sformatf("%s%0d", sign_text(), $urandom_range(999999999));
      8: return $sformatf("%s%0d", sign_text(), $urandom_range(70000, 30000));
      default: return sign_text();
    endcase
  endfunction

  function automatic string colour_token();
    case ($urandom_range(10))
      0, 1: return mixed_case("blue");
      2, 3: return mixed_case("purple");
      4, 5: return mixed_case("brown");
      6: return mixed_case("green");
      7: return "none";
      8: return "blu";
      9: return "browns";
      default: return "";
    endcase
  endfunction

  function automatic void build_random_line();
    int kind;
    int n;
    int i;
    kind = $urandom_range(99);
    if (kind < 30) begin
      case ($urandom_range(5))
        0: add_text({"E:", number_text(), ","});
        1: add_text("xC");
        2: add_text("T:9 ");
        default: ;
      endcase
      add_text({mixed_case("c:"), blanks(), colour_token()});
      case ($urandom_range(3))
        0: add_text({",E:", blanks(), number_text()});
        1: add_text({" e:", number_text()});
        2: add_text(",");
        default: ;
      endcase
    end else if (kind < 65) begin
      case ($urandom_range(5))
        0: add_text("S:1,");
        1: add_text({"C:", mixed_case("green"), ","});
        2: add_text("C:red ");
        3: add_text("e");
        default: ;
      endcase
      add_text({mixed_case("e:"), blanks(), number_text()});
      case ($urandom_range(3))
        0: add_text(",");
        1: add_text("x7");
        default: ;
      endcase
    end else if (kind < 78) begin
      add_text({blanks(), number_text()});
      if ($urandom_range(2) == 0) begin
        add_text(" ok");
      end
    end else if (kind < 86) begin
      n = $urandom_range(20, 1);
      for (i = 0; i < n; i++) begin
        draft.push_back(8'($urandom_range(126, 32)));
      end
    end else if (kind < 94) begin
      n = $urandom_range(12, 1);
      for (i = 0; i < n; i++) begin
        draft.push_back(8'($urandom_range(255)));
      end
    end else begin
      // around the line limit: LINE_DEPTH-8 to LINE_DEPTH+12 characters before the terminator
      n = $urandom_range(LINE_DEPTH + 12, LINE_DEPTH - 8);
      add_text({"E:", number_text(), " "});
      while (draft.size() < n) begin
        draft.push_back(8'($urandom_range(126, 97)));
      end
    end
    case ($urandom_range(5))
      0: begin
        draft.push_back(CHAR_CR);
        draft.push_back(CHAR_LF);
      end
      1, 2: draft.push_back(CHAR_CR);
      default: draft.push_back(CHAR_LF);
    endcase
  endfunction

  always @(posedge clk) begin
    if (calm) begin
      out_ready <= 1'b1;
      hold_left <= 0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      pick = $urandom_range(99);
      if (pick < 65) begin
        out_ready <= 1'b1;
      end else if (pick < 95) begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(3);
      end else begin
        out_ready <= 1'b0;
        hold_left <= $urandom_range(90, 30);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (pending_scans.size() == 0) begin
        fail_count++;
        if (fail_count <= 10) begin
          $display("unexpected result: is_command=%0b code=%0d error=%0d",
                   is_command, command_code, track_error);
        end
      end else begin
        want = pending_scans.pop_front();
        if (is_command !== want.is_command || command_code !== want.command_code ||
            track_error !== want.track_error) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("mismatch: expected is_command=%0b code=%0d error=%0d, got %0b %0d %0d",
                     want.is_command, want.command_code, $signed(want.track_error),
                     is_command, command_code, track_error);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** text_line_command_parser_core: FAILED **");
      $finish;
    end
  end

  task automatic test_colour_commands();
    send_line("C:blue", CHAR_LF);
    send_line("c: PURPLE,E:12", CHAR_CR);
    send_line("C:\tBrOwN E:9999", CHAR_LF);
    send_line("C:green,E:-5", CHAR_LF);
    send_line("C:none", CHAR_LF);
    send_line("C:bluex,E:7", CHAR_CR);
    send_line("xC:blue", CHAR_CR);
    draft.push_back(CHAR_LF);  // LF after CR: empty line
    send_draft();
  endtask

  task automatic test_event_codes();
    send_line("E:1000", CHAR_LF);
    send_line("e:-1000", CHAR_LF);
    send_line("E: 2000", CHAR_CR);
    send_line("+3000", CHAR_LF);
    send_line("E:4000", CHAR_LF);
    send_line("9999", CHAR_CR);
  endtask

  task automatic test_track_errors();
    send_line("E:0", CHAR_LF);
    send_line("E:32767", CHAR_LF);
    send_line("E:-32768", CHAR_LF);
    send_line("E:65536", CHAR_CR);
    send_line("E:65535", CHAR_LF);
    send_line("E:-", CHAR_LF);
    send_line("hello", CHAR_LF);
    send_line("E:12abc", CHAR_LF);
    send_line("E:+-3", CHAR_LF);
    send_line("C:", CHAR_LF);
  endtask

  task automatic test_line_overflow();
    int i;
    // exactly full line still scans
    add_text("E:-77");
    for (i = 5; i < LINE_DEPTH - 1; i++) begin
      draft.push_back("x");
    end
    send_line("", CHAR_LF);
    // one byte past full drops the line and that byte
    add_text("E:5");
    for (i = 3; i < LINE_DEPTH; i++) begin
      draft.push_back("y");
    end
    send_line("E:6", CHAR_LF);
    draft.push_back(8'h00);
    draft.push_back(8'hFF);
    send_line(" E:3", CHAR_CR);
  endtask

  task automatic test_empty_lines();
    send_line("", CHAR_LF);
    send_line("", CHAR_CR);
    send_line("", CHAR_LF);
    send_line("E:1", CHAR_LF);
  endtask

  task automatic test_pause_until_drained();
    repeat (4) begin
      build_random_line();
      send_draft();
    end
    wait_drained();
    repeat (4) begin
      build_random_line();
      send_draft();
    end
  endtask

  task automatic test_random_lines();
    int start;
    start = bytes_sent;
    while (bytes_sent - start < RANDOM_BYTES) begin
      calm = ($urandom_range(9) == 0);
      build_random_line();
      send_draft();
    end
    calm = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    test_colour_commands();
    test_event_codes();
    test_track_errors();
    test_line_overflow();
    test_empty_lines();
    test_pause_until_drained();
    test_random_lines();
    wait_drained();
    fail_count += pending_scans.size();
    if (fail_count == 0) begin
      $display("** text_line_command_parser_core: PASSED **");
    end else begin
      $display("** text_line_command_parser_core: FAILED **");
    end
    $finish;
  end

endmodule
